// File: design/salru_pkg.sv
// Shared constants and helpers for the set-associative cache tag and LRU controller.
package salru_pkg;

    localparam int ADDR_W           = 32;
    localparam int NUM_SETS         = 16;
    localparam int NUM_WAYS         = 4;
    localparam int BLOCK_BYTES_LOG2 = 6;

    localparam int SET_W   = $clog2(NUM_SETS);
    localparam int WAY_W   = $clog2(NUM_WAYS);
    localparam int TAG_W   = ADDR_W - BLOCK_BYTES_LOG2 - SET_W;
    localparam int BLOCK_W = ADDR_W - BLOCK_BYTES_LOG2;
    localparam int REC_W   = NUM_WAYS * WAY_W;
    localparam int LINE_W  = REC_W + NUM_WAYS * TAG_W;

    typedef logic [WAY_W-1:0] way_t;
    typedef logic [REC_W-1:0] order_t;

    // Recency list after reset: ways in ascending order, oldest in position 0.
    function automatic order_t reset_order();
        order_t r;
        r = '0;
        for (int i = 0; i < NUM_WAYS; i++)
        begin
            r[i*WAY_W +: WAY_W] = way_t'(i);
        end
        return r;
    endfunction

endpackage

// File: design/salru_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module salru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/set_assoc_cache_tag_lru_controller_core.sv
// Top level: tag, valid, dirty and LRU controller of a write-back, write-allocate cache.
//
//  channel | signals                                              | dir
//  in      | in_valid, in_stall, mode, address                    | into block
//  out     | out_valid, out_stall, hit, set_index, way_used,      | out of block
//          | word_offset, fill_needed, writeback_needed,          |
//          | victim_block                                         |
//
// The set's tags and recency list are read from the line RAM on the accept edge, then
// compared, updated and written back in the lookup state, which holds on a stalled output.
// Reset clears valid, dirty and recency-written flags at once; no clearing pass.
// A new beat is taken while a result waits; the lookup holds while the output is stalled.
module set_assoc_cache_tag_lru_controller_core
    import salru_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               mode,
    input  logic [ADDR_W-1:0]  address,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               hit,
    output logic [SET_W-1:0]   set_index,
    output logic [WAY_W-1:0]   way_used,
    output logic [BLOCK_BYTES_LOG2-1:0] word_offset,
    output logic               fill_needed,
    output logic               writeback_needed,
    output logic [BLOCK_W-1:0] victim_block
);

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_LOOKUP = 1'b1;

    logic                state_reg, state_next;
    logic                mode_reg;
    logic [ADDR_W-1:0]   address_reg;

    logic [NUM_WAYS-1:0] valid_reg [NUM_SETS];
    logic [NUM_WAYS-1:0] dirty_reg [NUM_SETS];
    logic [NUM_SETS-1:0] rec_written_reg;

    logic                out_valid_reg;
    logic                hit_reg;
    logic [SET_W-1:0]    set_index_reg;
    logic [WAY_W-1:0]    way_used_reg;
    logic [BLOCK_BYTES_LOG2-1:0] word_offset_reg;
    logic                writeback_reg;
    logic [BLOCK_W-1:0]  victim_reg;

    logic                in_fire;
    logic                lookup_fire;
    logic [LINE_W-1:0]   ram_rdata;
    logic [LINE_W-1:0]   ram_wdata;

    logic [SET_W-1:0]    cur_set;
    logic [TAG_W-1:0]    cur_tag;
    order_t              order;
    order_t              order_new;
    logic                hit_c;
    way_t                hit_way;
    way_t                way_c;
    way_t                pos_c;
    logic                wb_c;
    logic [TAG_W-1:0]    victim_tag;
    logic [NUM_WAYS-1:0] cur_valid;
    logic [NUM_WAYS-1:0] cur_dirty;

    assign in_stall    = (state_reg == ST_LOOKUP);
    assign in_fire     = in_valid && !in_stall;
    assign lookup_fire = (state_reg == ST_LOOKUP) && (!out_valid_reg || !out_stall);

    salru_ram #(
        .WIDTH (LINE_W),
        .DEPTH (NUM_SETS)
    ) u_line_ram (
        .clk   (clk),
        .we    (lookup_fire),
        .waddr (cur_set),
        .wdata (ram_wdata),
        .re    (in_fire),
        .raddr (address[BLOCK_BYTES_LOG2 +: SET_W]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        cur_set   = address_reg[BLOCK_BYTES_LOG2 +: SET_W];
        cur_tag   = address_reg[ADDR_W-1 -: TAG_W];
        cur_valid = valid_reg[cur_set];
        cur_dirty = dirty_reg[cur_set];
        order     = rec_written_reg[cur_set] ? ram_rdata[REC_W-1:0] : reset_order();

        hit_c   = 1'b0;
        hit_way = '0;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            if (cur_valid[w] && (ram_rdata[REC_W + w*TAG_W +: TAG_W] == cur_tag))
            begin
                hit_c   = 1'b1;
                hit_way = way_t'(w);
            end
        end

        way_c      = hit_c ? hit_way : order[WAY_W-1:0];
        victim_tag = ram_rdata[REC_W + way_c*TAG_W +: TAG_W];
        wb_c       = !hit_c && cur_valid[way_c] && cur_dirty[way_c];

        pos_c = '0;
        for (int i = 0; i < NUM_WAYS; i++)
        begin
            if (order[i*WAY_W +: WAY_W] == way_c)
            begin
                pos_c = way_t'(i);
            end
        end

        order_new = order;
        for (int i = 0; i < NUM_WAYS - 1; i++)
        begin
            if (way_t'(i) >= pos_c)
            begin
                order_new[i*WAY_W +: WAY_W] = order[(i+1)*WAY_W +: WAY_W];
            end
        end
        order_new[(NUM_WAYS-1)*WAY_W +: WAY_W] = way_c;

        ram_wdata = ram_rdata;
        ram_wdata[REC_W-1:0] = order_new;
        if (!hit_c)
        begin
            ram_wdata[REC_W + way_c*TAG_W +: TAG_W] = cur_tag;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (lookup_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            out_valid_reg   <= 1'b0;
            rec_written_reg <= '0;
            for (int s = 0; s < NUM_SETS; s++)
            begin
                valid_reg[s] <= '0;
                dirty_reg[s] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (lookup_fire)
            begin
                out_valid_reg            <= 1'b1;
                rec_written_reg[cur_set] <= 1'b1;
                if (hit_c)
                begin
                    if (mode_reg)
                    begin
                        dirty_reg[cur_set][way_c] <= 1'b1;
                    end
                end
                else
                begin
                    valid_reg[cur_set][way_c] <= 1'b1;
                    dirty_reg[cur_set][way_c] <= mode_reg;
                end
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            mode_reg    <= mode;
            address_reg <= address;
        end
        if (lookup_fire)
        begin
            hit_reg         <= hit_c;
            set_index_reg   <= cur_set;
            way_used_reg    <= way_c;
            word_offset_reg <= address_reg[BLOCK_BYTES_LOG2-1:0];
            writeback_reg   <= wb_c;
            victim_reg      <= wb_c ? {victim_tag, cur_set} : '0;
        end
    end

    assign out_valid        = out_valid_reg;
    assign hit              = hit_reg;
    assign set_index        = set_index_reg;
    assign way_used         = way_used_reg;
    assign word_offset      = word_offset_reg;
    assign fill_needed      = !hit_reg;
    assign writeback_needed = writeback_reg;
    assign victim_block     = victim_reg;

endmodule
